>>> src/cordic_sine_wave_generator_top_defines.svh
// assertion macros for the cordic sine wave generator checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CORDIC_SINE_WAVE_GENERATOR_TOP_DEFINES_SVH
`define CORDIC_SINE_WAVE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define CSG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after reset is seen
`define CSG_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

>>> src/csg_pkg.sv
// shared types, constants and the arctangent table of the sine wave generator
// no dependencies
package csg_pkg;

    // x and y are q2.30 with headroom, angles are radians scaled by 2^16
    localparam int XY_W  = 34;
    localparam int ANG_W = 18;
    localparam int FOLD_W = 19;

    localparam logic [FOLD_W-1:0] HALF_PI_FX       = 19'd102944;
    localparam logic [FOLD_W-1:0] PI_FX            = 19'd205887;
    localparam logic [FOLD_W-1:0] THREE_HALF_PI_FX = 19'd308831;
    localparam logic [FOLD_W-1:0] TWO_PI_FX        = 19'd411775;

    // cordic gain for an infinite number of steps, q30
    localparam longint K_INF_Q30 = 64'd652032874;

    typedef enum logic [1:0] {
        QUAD_1,
        QUAD_2,
        QUAD_3,
        QUAD_4
    } t_quad;

    // data handed from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] ca;
        logic signed [ANG_W-1:0] target;
        t_quad                   quad;
        logic [15:0]             phase;
    } t_cordic_data;

    // atan(2^-i) scaled by 2^16, rounded
    function automatic logic signed [ANG_W-1:0] atan_fx(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 18'sd51472;
            1:       v = 18'sd30386;
            2:       v = 18'sd16055;
            3:       v = 18'sd8150;
            4:       v = 18'sd4091;
            5:       v = 18'sd2047;
            6:       v = 18'sd1024;
            7:       v = 18'sd512;
            8:       v = 18'sd256;
            9:       v = 18'sd128;
            10:      v = 18'sd64;
            11:      v = 18'sd32;
            12:      v = 18'sd16;
            13:      v = 18'sd8;
            14:      v = 18'sd4;
            15:      v = 18'sd2;
            16:      v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/csg_front.sv
// phase accumulator, step register, phase-to-radian multiply and quadrant fold
// depends on csg_pkg
module csg_front import csg_pkg::*; #(
    parameter int ITERATIONS = 16,
    parameter int PHASE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_restart,
    output logic         o_ready,
    input  logic         i_cfg_valid,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_ready,
    output logic         o_valid,
    output t_cordic_data o_data
);

    localparam int PROD_W = PHASE_BITS + FOLD_W;
    localparam int SW     = (PHASE_BITS > 16) ? PHASE_BITS : 16;
    localparam longint K_Q30 = K_INF_Q30 + ((K_INF_Q30 * 2 / 3) >> (2 * ITERATIONS));

    logic [PHASE_BITS-1:0] r_acc;
    logic [PHASE_BITS-1:0] n_acc;
    logic [15:0]           r_step;
    logic [PHASE_BITS-1:0] w_phase;
    logic [SW-1:0]         w_step_ext;
    logic [SW-1:0]         w_phase_ext;
    logic                  w_adv_b;
    logic                  w_adv_c;
    logic                  w_accept;

    logic                  r_b_valid;
    logic [PHASE_BITS-1:0] r_b_phase;
    logic [PROD_W-1:0]     r_b_prod;
    logic [PROD_W-1:0]     n_b_prod;

    logic                  r_c_valid;
    t_cordic_data          r_c_data;
    t_cordic_data          n_c_data;
    logic [FOLD_W-1:0]     w_ang;

    // stall chain: a stage moves when it is empty or its successor moves
    assign w_adv_c  = ~r_c_valid | i_ready;
    assign w_adv_b  = ~r_b_valid | w_adv_c;
    assign o_ready  = w_adv_b;
    assign w_accept = i_valid & w_adv_b;

    // phase for this item and the next accumulator value
    assign w_phase    = i_restart ? '0 : r_acc;
    assign w_step_ext = SW'(r_step);
    assign n_acc      = w_phase + w_step_ext[PHASE_BITS-1:0];
    assign n_b_prod   = PROD_W'(w_phase) * PROD_W'(TWO_PI_FX);

    // step register and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 16'd655;
            r_acc  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            if (w_accept) begin
                r_acc <= n_acc;
            end
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv_b) begin
            r_b_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_phase <= w_phase;
            r_b_prod  <= n_b_prod;
        end
    end

    // fold into the first quadrant, boundary angles go to the lower quadrant
    assign w_ang       = r_b_prod[PROD_W-1:PHASE_BITS];
    assign w_phase_ext = SW'(r_b_phase);

    always_comb begin
        n_c_data       = '0;
        n_c_data.x     = XY_W'(K_Q30);
        n_c_data.y     = '0;
        n_c_data.ca    = '0;
        n_c_data.phase = w_phase_ext[15:0];
        if (w_ang <= HALF_PI_FX) begin
            n_c_data.quad   = QUAD_1;
            n_c_data.target = ANG_W'(w_ang);
        end else if (w_ang <= PI_FX) begin
            n_c_data.quad   = QUAD_2;
            n_c_data.target = ANG_W'(PI_FX - w_ang);
        end else if (w_ang <= THREE_HALF_PI_FX) begin
            n_c_data.quad   = QUAD_3;
            n_c_data.target = ANG_W'(w_ang - PI_FX);
        end else begin
            n_c_data.quad   = QUAD_4;
            n_c_data.target = ANG_W'(TWO_PI_FX - w_ang);
        end
    end

    // fold stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_c && r_b_valid) begin
            r_c_data <= n_c_data;
        end
    end

    assign o_valid = r_c_valid;
    assign o_data  = r_c_data;

endmodule

>>> src/csg_cordic_cell.sv
// one rotation-mode cordic step with its pipeline register
// depends on csg_pkg
module csg_cordic_cell import csg_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_cordic_data i_data,
    input  logic         i_ready,
    output logic         o_valid,
    output t_cordic_data o_data
);

    localparam logic signed [ANG_W-1:0] ATAN = atan_fx(STAGE);

    logic                   r_valid;
    t_cordic_data           r_data;
    t_cordic_data           n_data;
    logic                   w_adv;
    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;

    assign w_adv   = ~r_valid | i_ready;
    assign o_ready = w_adv;

    // arithmetic shifts round toward minus infinity
    assign w_xs = i_data.x >>> STAGE;
    assign w_ys = i_data.y >>> STAGE;

    // rotate toward the target, hold when the angles match
    always_comb begin
        n_data = i_data;
        if (i_data.ca < i_data.target) begin
            n_data.ca = i_data.ca + ATAN;
            n_data.x  = i_data.x - w_ys;
            n_data.y  = i_data.y + w_xs;
        end else if (i_data.ca > i_data.target) begin
            n_data.ca = i_data.ca - ATAN;
            n_data.x  = i_data.x + w_ys;
            n_data.y  = i_data.y - w_xs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/csg_back.sv
// sign restore, q1.15 rounding and saturation, 8-bit code, output register
// depends on csg_pkg
module csg_back import csg_pkg::*; #(
    parameter int OUT_SCALE_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_cordic_data       i_data,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [7:0]         o_code,
    output logic signed [15:0] o_sine,
    output logic signed [15:0] o_cosine,
    output logic signed [17:0] o_angle,
    output logic [15:0]        o_phase
);

    localparam int VW = ((16 + OUT_SCALE_BITS) > 25 ? 16 + OUT_SCALE_BITS : 25) + 1;
    localparam logic signed [VW-1:0] CODE_OFFSET = VW'(255 * 32768);

    // round q30 to q15 and clamp
    function automatic logic signed [15:0] round_sat(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        r = (v + XY_W'(16384)) >>> 15;
        if (r > XY_W'(32767)) begin
            return 16'sd32767;
        end else if (r < -XY_W'(32768)) begin
            return -16'sd32768;
        end
        return r[15:0];
    endfunction

    logic                    w_adv_d;
    logic                    w_adv_e;
    logic signed [XY_W-1:0]  w_x;
    logic signed [XY_W-1:0]  w_y;

    logic                    r_d_valid;
    logic signed [15:0]      r_d_sine;
    logic signed [15:0]      r_d_cosine;
    logic signed [ANG_W-1:0] r_d_angle;
    logic [15:0]             r_d_phase;
    logic signed [15:0]      n_d_sine;
    logic signed [15:0]      n_d_cosine;

    logic signed [VW-1:0]    w_v;
    logic signed [VW-1:0]    w_hi;
    logic [7:0]              n_code;

    logic                    r_e_valid;
    logic [7:0]              r_code;
    logic signed [15:0]      r_sine;
    logic signed [15:0]      r_cosine;
    logic signed [ANG_W-1:0] r_angle;
    logic [15:0]             r_phase;

    assign w_adv_e = ~r_e_valid | i_ready;
    assign w_adv_d = ~r_d_valid | w_adv_e;
    assign o_ready = w_adv_d;

    // restore signs per quadrant
    always_comb begin
        w_x = i_data.x;
        w_y = i_data.y;
        if (i_data.quad inside {QUAD_2, QUAD_3}) begin
            w_x = -i_data.x;
        end
        if (i_data.quad inside {QUAD_3, QUAD_4}) begin
            w_y = -i_data.y;
        end
    end

    assign n_d_sine   = round_sat(w_y);
    assign n_d_cosine = round_sat(w_x);

    // rounding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_adv_d) begin
            r_d_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_d && i_valid) begin
            r_d_sine   <= n_d_sine;
            r_d_cosine <= n_d_cosine;
            r_d_angle  <= i_data.ca;
            r_d_phase  <= i_data.phase;
        end
    end

    // unsigned code of the sine, negative sums give zero
    assign w_v  = (VW'(r_d_sine) <<< OUT_SCALE_BITS) + CODE_OFFSET;
    assign w_hi = w_v >>> 16;

    always_comb begin
        if (w_v <= VW'(0)) begin
            n_code = 8'd0;
        end else if (w_hi > VW'(255)) begin
            n_code = 8'd255;
        end else begin
            n_code = w_hi[7:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_adv_e) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_e && r_d_valid) begin
            r_code   <= n_code;
            r_sine   <= r_d_sine;
            r_cosine <= r_d_cosine;
            r_angle  <= r_d_angle;
            r_phase  <= r_d_phase;
        end
    end

    assign o_valid  = r_e_valid;
    assign o_code   = r_code;
    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;
    assign o_angle  = r_angle;
    assign o_phase  = r_phase;

endmodule

>>> src/cordic_sine_wave_generator_top.sv
// top level of the cordic sine wave generator: front end, cell row, back end
// depends on csg_pkg, csg_front, csg_cordic_cell, csg_back
//
// usage
//   each item on the slave stream (s_axis_tdata bit 0 = restart) asks for one
//   sample. restart set clears the phase accumulator before the sample is made;
//   the accumulator then advances by the phase step register.
//   the config channel (i_cfg_valid, i_cfg_data) writes the phase step; it is
//   always ready and should be written only while the block is idle.
//   each sample leaves on the master stream as one item.
// timing
//   one item per cycle sustained while m_axis_tready stays high. between the
//   accepting edge and the result item lie these registers in order:
//   one multiply stage, one fold stage, one cell per cordic step, one rounding
//   stage and the output register.
// reset
//   synchronous, active low: pipeline emptied, accumulator zero, step 655.
// stalls
//   when m_axis_tready is low the output item holds; stages behind it keep
//   filling bubbles and s_axis_tready drops only once the whole row is full.
module cordic_sine_wave_generator_top import csg_pkg::*; #(
    parameter int ITERATIONS     = 16,
    parameter int PHASE_BITS     = 16,
    parameter int OUT_SCALE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] restart, [7:1] zero
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] sample_code, [23:8] sine_value, [39:24] cosine_value,
    // [57:40] reached_angle, [73:58] phase_now, [79:74] zero
    output logic [79:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_cordic_data       w_chain_data  [ITERATIONS+1];
    logic               w_chain_valid [ITERATIONS+1];
    logic               w_chain_ready [ITERATIONS+1];
    logic [7:0]         w_code;
    logic signed [15:0] w_sine;
    logic signed [15:0] w_cosine;
    logic signed [17:0] w_angle;
    logic [15:0]        w_phase;

    assign o_cfg_ready = 1'b1;

    // phase and fold
    csg_front #(
        .ITERATIONS (ITERATIONS),
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_restart   (s_axis_tdata[0]),
        .o_ready     (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_ready     (w_chain_ready[0]),
        .o_valid     (w_chain_valid[0]),
        .o_data      (w_chain_data[0])
    );

    // one cell per cordic step
    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        csg_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_chain_valid[g]),
            .o_ready (w_chain_ready[g]),
            .i_data  (w_chain_data[g]),
            .i_ready (w_chain_ready[g+1]),
            .o_valid (w_chain_valid[g+1]),
            .o_data  (w_chain_data[g+1])
        );
    end

    // rounding, code and output register
    csg_back #(
        .OUT_SCALE_BITS (OUT_SCALE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_chain_valid[ITERATIONS]),
        .o_ready  (w_chain_ready[ITERATIONS]),
        .i_data   (w_chain_data[ITERATIONS]),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_code   (w_code),
        .o_sine   (w_sine),
        .o_cosine (w_cosine),
        .o_angle  (w_angle),
        .o_phase  (w_phase)
    );

    assign m_axis_tdata = {6'd0, w_phase, w_angle, w_cosine, w_sine, w_code};

endmodule

>>> src/csg_checker.sv
// port-level checks of the sine wave generator, bound to the top level
// depends on cordic_sine_wave_generator_top_defines.svh
`include "cordic_sine_wave_generator_top_defines.svh"

module csg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    // a stalled output item holds
    `CSG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")

    // reset empties the pipeline
    `CSG_ASSERT_RESET(a_reset_empty, !m_axis_tvalid, "output valid after reset")

    // code and sine agree in sign around mid scale
    `CSG_ASSERT_IMPL(a_code_pos, m_axis_tvalid && !m_axis_tdata[23], m_axis_tdata[7:0] >= 8'd127, "code below mid scale for non-negative sine")

    `CSG_ASSERT_IMPL(a_code_neg, m_axis_tvalid && m_axis_tdata[23], m_axis_tdata[7:0] <= 8'd127, "code above mid scale for negative sine")

endmodule

bind cordic_sine_wave_generator_top csg_checker u_csg_checker (.*);

>>> verif/cordic_sine_wave_generator_top_tb.sv
// self-checking testbench for cordic_sine_wave_generator_top: phase sweeps, restarts, stalls
// depends on csg_pkg and the cordic_sine_wave_generator_top rtl
module cordic_sine_wave_generator_top_tb import csg_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITERATIONS     = 16;
    localparam int PHASE_BITS     = 16;
    localparam int OUT_SCALE_BITS = 8;
    localparam int LATENCY        = ITERATIONS + 4;

    // one output item, msb first so it lines up with m_axis_tdata
    typedef struct packed {
        logic [5:0]         pad;
        logic [15:0]        phase_now;
        logic signed [17:0] reached_angle;
        logic signed [15:0] cosine_value;
        logic signed [15:0] sine_value;
        logic [7:0]         sample_code;
    } t_sample;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    // oscillator state mirrored by the testbench
    logic [15:0] osc_phase;
    logic [15:0] osc_step;

    // atan(2^-i) in radians scaled by 2^16
    longint atan_step [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};

    t_sample pending_samples[$];
    int      mismatch_count = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      idle_plan [4] = '{0, 58, 0, 23};
    int      stall_plan [4] = '{0, 0, 58, 23};

    cordic_sine_wave_generator_top #(
        .ITERATIONS    (ITERATIONS),
        .PHASE_BITS    (PHASE_BITS),
        .OUT_SCALE_BITS(OUT_SCALE_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint clamp_q15(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // one sample for the current phase, then advance the accumulator
    function automatic t_sample synth_sample(input logic restart);
        logic [15:0] phase;
        longint      ang, target, ca, x, y, xs, ys, k, sn, cs, v, code;
        t_quad       quad;
        t_sample     s;
        if (restart)
            osc_phase = '0;
        phase = osc_phase;
        ang = (longint'(phase) * longint'(TWO_PI_FX)) >>> PHASE_BITS;

        // fold into the first quadrant, boundaries go to the lower quadrant
        if (ang <= longint'(HALF_PI_FX)) begin
            quad = QUAD_1;
            target = ang;
        end else if (ang <= longint'(PI_FX)) begin
            quad = QUAD_2;
            target = longint'(PI_FX) - ang;
        end else if (ang <= longint'(THREE_HALF_PI_FX)) begin
            quad = QUAD_3;
            target = ang - longint'(PI_FX);
        end else begin
            quad = QUAD_4;
            target = longint'(TWO_PI_FX) - ang;
        end

        // rotation mode, no turn when the angle is hit exactly
        k = K_INF_Q30 + ((K_INF_Q30 * 2 / 3) >>> (2 * ITERATIONS));
        x = k;
        y = 0;
        ca = 0;
        for (int i = 0; i < ITERATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (ca < target) begin
                ca = ca + atan_step[i];
                x = x - ys;
                y = y + xs;
            end else if (ca > target) begin
                ca = ca - atan_step[i];
                x = x + ys;
                y = y - xs;
            end
        end

        // restore signs per quadrant
        if (quad == QUAD_2 || quad == QUAD_3)
            x = -x;
        if (quad == QUAD_3 || quad == QUAD_4)
            y = -y;

        cs = clamp_q15((x + (1 << 14)) >>> 15);
        sn = clamp_q15((y + (1 << 14)) >>> 15);

        // 8-bit code, negative sums go to zero
        v = sn * (longint'(1) << OUT_SCALE_BITS) + 255 * 32768;
        if (v <= 0)
            code = 0;
        else
            code = v >>> 16;
        if (code > 255)
            code = 255;

        s = '0;
        s.sample_code   = code[7:0];
        s.sine_value    = sn[15:0];
        s.cosine_value  = cs[15:0];
        s.reached_angle = ca[17:0];
        s.phase_now     = phase;
        osc_phase = phase + osc_step;
        return s;
    endfunction

    task automatic note_mismatch(input string field, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= stall_pct);
    end

    // compare each output item with the oldest prediction
    always @(posedge i_clk) begin : check_output
        t_sample got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_samples.size() == 0) begin
                note_mismatch("unexpected item phase_now", -1, got.phase_now);
            end else begin
                want = pending_samples.pop_front();
                if (got.sample_code != want.sample_code)
                    note_mismatch("sample_code", want.sample_code, got.sample_code);
                if (got.sine_value != want.sine_value)
                    note_mismatch("sine_value", want.sine_value, got.sine_value);
                if (got.cosine_value != want.cosine_value)
                    note_mismatch("cosine_value", want.cosine_value, got.cosine_value);
                if (got.reached_angle != want.reached_angle)
                    note_mismatch("reached_angle", want.reached_angle, got.reached_angle);
                if (got.phase_now != want.phase_now)
                    note_mismatch("phase_now", want.phase_now, got.phase_now);
            end
        end
    end

    // send one tick item, then maybe leave a gap
    task automatic send_tick(input logic restart);
        s_axis_tdata = {7'b0, restart};
        s_axis_tvalid = 1'b1;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pending_samples.push_back(synth_sample(restart));
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    // stop sending and wait for every predicted sample
    task automatic finish_outstanding();
        s_axis_tvalid = 1'b0;
        while (pending_samples.size() != 0)
            @(negedge i_clk);
    endtask

    // phase step write, only once the pipeline is empty
    task automatic set_phase_step(input logic [15:0] step);
        finish_outstanding();
        i_cfg_data = step;
        i_cfg_valid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        osc_step = step;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // reset step value, first sample at zero phase, restart mid-run
    task automatic test_reset_step();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // quarter-turn steps land on and just below the quadrant boundaries,
    // full-scale sine saturates and the bottom of the wave gives code zero
    task automatic test_quadrant_edges();
        set_phase_step(16'd16384);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        set_phase_step(16'd16383);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
    endtask

    // largest step wraps backwards, zero step holds the phase
    task automatic test_step_extremes();
        set_phase_step(16'hFFFF);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        set_phase_step(16'd0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // random sweeps under each idling and stalling pattern, with a full drain mid-segment
    task automatic test_random_sweeps();
        logic [15:0] step;
        for (int mode = 0; mode < 4; mode++) begin
            idle_pct = idle_plan[mode];
            stall_pct = stall_plan[mode];
            for (int seg = 0; seg < 3; seg++) begin
                case ((mode * 3 + seg) % 6)
                    0:       step = 16'd0;
                    1:       step = 16'hFFFF;
                    2:       step = 16'd1;
                    3:       step = 16'h8000;
                    default: step = 16'($urandom_range(65535));
                endcase
                set_phase_step(step);
                for (int n = 0; n < 88; n++) begin
                    if (n == 44)
                        finish_outstanding();
                    send_tick($urandom_range(99) < 4);
                end
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        osc_phase = '0;
        osc_step = 16'd655;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_step();
        test_quadrant_edges();
        test_step_extremes();
        test_random_sweeps();

        finish_outstanding();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("cordic_sine_wave_generator_top test passed");
        else
            $display("cordic_sine_wave_generator_top test failed");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("cordic_sine_wave_generator_top test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/csg_pkg.sv
src/csg_front.sv
src/csg_cordic_cell.sv
src/csg_back.sv
src/cordic_sine_wave_generator_top.sv
src/csg_checker.sv
verif/cordic_sine_wave_generator_top_tb.sv
